/* rtl/psfrm_pkg.sv */
// Shared constants and types for the per-stream frame rate meter.
// No dependencies; the interfaces, the top level and the testbench import this package.
package psfrm_pkg;

  localparam int SLOTS_DEF      = 8;
  localparam int RING_DEPTH_DEF = 256;

  // Payload field widths
  localparam int FUNC_W  = 2;
  localparam int PID_W   = 32;
  localparam int CHAIN_W = 64;
  localparam int TIME_W  = 48;
  localparam int TICK_W  = 64;
  localparam int RATE_W  = 14;

  // Configuration
  localparam int CFG_DATA_W = 40;
  localparam int MS_W       = 11;
  localparam int WIN_W      = 21;
  localparam int TR5_W      = 43;
  localparam int SMOOTH_LO  = 250;
  localparam int SMOOTH_HI  = 1250;
  localparam int SMOOTH_RST = 1000;
  localparam int MS_TO_US   = 1000;
  localparam longint unsigned TICK_RATE_RST = 64'd10000000;

  typedef enum logic [0:0] {
    CFG_SMOOTHING = 1'b0,
    CFG_TICK_RATE = 1'b1
  } cfg_idx_e;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_RECORD   = 2'd0,
    FUNC_SNAPSHOT = 2'd1,
    FUNC_CLEAR    = 2'd2,
    FUNC_NONE     = 2'd3
  } func_e;

  // Rate arithmetic
  localparam int MIN_SPAN_US = 50;
  localparam int RATE_SCALE  = 256000000;
  localparam int SCALE_W     = 28;
  localparam int Q_W         = 22;
  localparam int RATE_LO_Q8  = 256;
  localparam int RATE_HI_Q8  = 9999 * 256;
  localparam int ROUND_Q8    = 128;

endpackage

/* rtl/psfrm_if.sv */
// Request and response channel interfaces of the frame rate meter.
// Depends on psfrm_pkg for the field widths.
interface psfrm_req_if import psfrm_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic [PID_W-1:0]         src_pid;
  logic [CHAIN_W-1:0]       chain_id;
  logic [TIME_W-1:0]        event_time_us;
  logic signed [TICK_W-1:0] tick_time;
  logic                     is_game;
  logic                     only_games;

  modport source (output valid, func, src_pid, chain_id, event_time_us, tick_time,
                  is_game, only_games, input ready);
  modport sink   (input valid, func, src_pid, chain_id, event_time_us, tick_time,
                  is_game, only_games, output ready);
endinterface

interface psfrm_rsp_if import psfrm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              available;
  logic [RATE_W-1:0] rate_fps;
  logic [PID_W-1:0]  chosen_process;
  logic              accepted;

  modport source (output valid, available, rate_fps, chosen_process, accepted, input ready);
  modport sink   (input valid, available, rate_fps, chosen_process, accepted, output ready);
endinterface

/* rtl/per_stream_frame_rate_meter.sv */
// Per-stream frame rate meter: slot table in flops, time rings in one RAM.
// Record: scans the slots, then reads the last time, appends and trims old times one
// at a time. Snapshot: per slot, skips it or trims a private copy of its window and
// divides. Ready returns together with the loaded result; the single ring RAM read
// port and the bit-serial divider set the pace.
// Reset (async, active low) empties the table and loads default registers; no clearing pass.
module per_stream_frame_rate_meter import psfrm_pkg::*; #(
  parameter int SLOTS      = SLOTS_DEF,
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  psfrm_req_if.sink             req,
  psfrm_rsp_if.source           rsp,
  input  logic                  cfg_we_i,
  input  logic [0:0]            cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PTR_W = $clog2(RING_DEPTH);
  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int MEM_N = SLOTS * RING_DEPTH;
  localparam int AW    = (MEM_N > 1) ? $clog2(MEM_N) : 1;
  localparam int NUM_W = SCALE_W + CNT_W;

  typedef struct packed {
    logic               valid;
    logic [PID_W-1:0]   process;
    logic [CHAIN_W-1:0] chain;
    logic               game;
    logic [TICK_W-1:0]  last_tick;
    logic [PTR_W-1:0]   head;
    logic [CNT_W-1:0]   fill;
  } slot_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_REC_SCAN, ST_REC_SEL, ST_REC_CLAIM, ST_REC_LAST_RD, ST_REC_LAST_CMP,
    ST_REC_APPEND, ST_REC_TRIM_RD, ST_REC_TRIM_CMP, ST_SNAP_CHK, ST_SNAP_FRESH,
    ST_SNAP_LAST_RD, ST_SNAP_LAST_GET, ST_SNAP_WIN_RD, ST_SNAP_WIN_CMP, ST_SNAP_DIV,
    ST_FINISH
  } state_e;

  function automatic logic [PTR_W-1:0] ring_pos(logic [PTR_W-1:0] base,
                                                logic [CNT_W-1:0] off);
    logic [CNT_W:0] s;
    s = (CNT_W+1)'(base) + {1'b0, off};
    if (s >= (CNT_W+1)'(RING_DEPTH)) s = s - (CNT_W+1)'(RING_DEPTH);
    return s[PTR_W-1:0];
  endfunction

  function automatic logic [AW-1:0] mem_addr(logic [SW-1:0] slot, logic [PTR_W-1:0] pos);
    return AW'(slot) * AW'(RING_DEPTH) + AW'(pos);
  endfunction

  state_e state_q;
  slot_t  slot_q [SLOTS];
  slot_t  cur;

  // Latched transaction
  logic [PID_W-1:0]   pid_q;
  logic [CHAIN_W-1:0] chain_q;
  logic [TIME_W-1:0]  t_q;
  logic [TICK_W-1:0]  tick_q;
  logic               game_q, gonly_q;

  logic [WIN_W-1:0] win_q;
  logic [TR5_W-1:0] tr5_q;

  logic [SW-1:0]     idx_q, sel_q, old_q;
  logic              hit_q, have_sel_q;
  logic [TICK_W-1:0] old_tick_q;
  logic [PTR_W-1:0]  pos_q, h_q;
  logic [CNT_W-1:0]  n_q;
  logic [TIME_W-1:0] last_q;
  logic [TICK_W-1:0] diff_q;

  logic             acc_q, avail_q, best_fg_q;
  logic [Q_W-1:0]   best_q_q;
  logic [PID_W-1:0] best_pid_q;

  logic              out_valid_q, out_avail_q, out_acc_q;
  logic [RATE_W-1:0] out_rate_q;
  logic [PID_W-1:0]  out_pid_q;

  logic [TIME_W-1:0] ring_mem [MEM_N];
  logic [TIME_W-1:0] ring_rd_q;
  logic [PTR_W-1:0]  rd_pos;
  logic              mem_we;

  logic [PTR_W-1:0]  app_head, app_pos;
  logic [CNT_W-1:0]  app_fill;
  logic              match, last_slot, fg, better, trim_hit;
  logic [SW-1:0]     idx_nxt;
  state_e            snap_nxt;
  logic [TIME_W-1:0] span;
  logic [Q_W:0]      rnd;
  logic [MS_W-1:0]   ms_clamped;
  logic              div_start, div_busy, div_done;
  logic [NUM_W-1:0]  div_num, div_quo;

  always_comb begin
    cur       = slot_q[idx_q];
    match     = cur.valid && cur.process == pid_q && cur.chain == chain_q;
    last_slot = idx_q == SW'(SLOTS - 1);
    idx_nxt   = last_slot ? idx_q : idx_q + SW'(1);
    snap_nxt  = last_slot ? ST_FINISH : ST_SNAP_CHK;
    // Full ring: drop the oldest before appending
    app_head  = (cur.fill >= CNT_W'(RING_DEPTH)) ? ring_pos(cur.head, CNT_W'(1)) : cur.head;
    app_fill  = (cur.fill >= CNT_W'(RING_DEPTH)) ? CNT_W'(RING_DEPTH - 1) : cur.fill;
    app_pos   = ring_pos(app_head, app_fill);
    mem_we    = state_q == ST_REC_APPEND;
    trim_hit  = ({1'b0, ring_rd_q} + (TIME_W+1)'(win_q)) <
                {1'b0, (state_q == ST_SNAP_WIN_CMP) ? last_q : t_q};
    span      = last_q - ring_rd_q;
    div_start = state_q == ST_SNAP_WIN_CMP && !(n_q > CNT_W'(1) && trim_hit) &&
                n_q >= CNT_W'(2) && span > TIME_W'(MIN_SPAN_US);
    div_num   = NUM_W'(RATE_SCALE) * NUM_W'(n_q - CNT_W'(1));
    fg        = cur.process == pid_q;
    better    = !avail_q || (fg && !best_fg_q) ||
                (fg == best_fg_q && div_quo > NUM_W'(best_q_q));
    rnd       = {1'b0, best_q_q} + (Q_W+1)'(ROUND_Q8);
    unique case (state_q)
      ST_REC_TRIM_RD: rd_pos = cur.head;
      ST_SNAP_WIN_RD: rd_pos = h_q;
      default:        rd_pos = pos_q;
    endcase
    if (cfg_data_i < CFG_DATA_W'(SMOOTH_LO))      ms_clamped = MS_W'(SMOOTH_LO);
    else if (cfg_data_i > CFG_DATA_W'(SMOOTH_HI)) ms_clamped = MS_W'(SMOOTH_HI);
    else                                          ms_clamped = cfg_data_i[MS_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) ring_mem[mem_addr(idx_q, app_pos)] <= t_q;
    ring_rd_q <= ring_mem[mem_addr(idx_q, rd_pos)];
  end

  psfrm_div #(.NUM_W(NUM_W), .DEN_W(TIME_W)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (span),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      for (int i = 0; i < SLOTS; i++) slot_q[i] <= '0;
      win_q       <= WIN_W'(SMOOTH_RST * MS_TO_US);
      tr5_q       <= TR5_W'(TICK_RATE_RST * 5);
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_SMOOTHING: win_q <= WIN_W'(ms_clamped) * WIN_W'(MS_TO_US);
          CFG_TICK_RATE: tr5_q <= {cfg_data_i, 2'b00} + TR5_W'(cfg_data_i);
          default: ;
        endcase
      end
      if (out_valid_q && rsp.ready && state_q != ST_FINISH) out_valid_q <= 1'b0;

      unique case (state_q)
        ST_IDLE: begin
          if (req.valid) begin
            pid_q      <= req.src_pid;
            chain_q    <= req.chain_id;
            t_q        <= req.event_time_us;
            tick_q     <= req.tick_time;
            game_q     <= req.is_game;
            gonly_q    <= req.only_games;
            idx_q      <= '0;
            hit_q      <= 1'b0;
            have_sel_q <= 1'b0;
            acc_q      <= 1'b0;
            avail_q    <= 1'b0;
            best_fg_q  <= 1'b0;
            best_q_q   <= '0;
            best_pid_q <= '0;
            unique case (req.func)
              FUNC_RECORD:   state_q <= (req.src_pid == '0) ? ST_FINISH : ST_REC_SCAN;
              FUNC_SNAPSHOT: state_q <= ST_SNAP_CHK;
              FUNC_CLEAR: begin
                for (int i = 0; i < SLOTS; i++) slot_q[i] <= '0;
                state_q <= ST_FINISH;
              end
              default:       state_q <= ST_FINISH;
            endcase
          end
        end

        ST_REC_SCAN: begin
          if (match) begin
            sel_q   <= idx_q;
            hit_q   <= 1'b1;
            state_q <= ST_REC_SEL;
          end else begin
            if (!cur.valid && !have_sel_q) begin
              sel_q      <= idx_q;
              have_sel_q <= 1'b1;
            end
            if (idx_q == '0 || $signed(cur.last_tick) < $signed(old_tick_q)) begin
              old_q      <= idx_q;
              old_tick_q <= cur.last_tick;
            end
            idx_q   <= idx_nxt;
            state_q <= last_slot ? ST_REC_SEL : ST_REC_SCAN;
          end
        end

        ST_REC_SEL: begin
          idx_q   <= (hit_q || have_sel_q) ? sel_q : old_q;
          state_q <= ST_REC_CLAIM;
        end

        ST_REC_CLAIM: begin
          if (!hit_q) begin
            slot_q[idx_q] <= '{valid: 1'b1, process: pid_q, chain: chain_q, game: game_q,
                               last_tick: '0, head: '0, fill: '0};
            state_q <= ST_REC_APPEND;
          end else if (cur.fill != '0) begin
            pos_q   <= ring_pos(cur.head, cur.fill - CNT_W'(1));
            state_q <= ST_REC_LAST_RD;
          end else begin
            state_q <= ST_REC_APPEND;
          end
        end

        ST_REC_LAST_RD: state_q <= ST_REC_LAST_CMP;

        ST_REC_LAST_CMP: begin
          // drop times that are not newer
          state_q <= (t_q <= ring_rd_q) ? ST_FINISH : ST_REC_APPEND;
        end

        ST_REC_APPEND: begin
          slot_q[idx_q].head      <= app_head;
          slot_q[idx_q].fill      <= app_fill + CNT_W'(1);
          slot_q[idx_q].last_tick <= tick_q;
          acc_q                   <= 1'b1;
          state_q                 <= ST_REC_TRIM_RD;
        end

        ST_REC_TRIM_RD: state_q <= (cur.fill > CNT_W'(1)) ? ST_REC_TRIM_CMP : ST_FINISH;

        ST_REC_TRIM_CMP: begin
          if (trim_hit) begin
            slot_q[idx_q].head <= ring_pos(cur.head, CNT_W'(1));
            slot_q[idx_q].fill <= cur.fill - CNT_W'(1);
            state_q            <= ST_REC_TRIM_RD;
          end else begin
            state_q <= ST_FINISH;
          end
        end

        ST_SNAP_CHK: begin
          if (!cur.valid || cur.fill < CNT_W'(2) || tr5_q == '0 ||
              $signed(tick_q) < $signed(cur.last_tick) || (gonly_q && !cur.game)) begin
            idx_q   <= idx_nxt;
            state_q <= snap_nxt;
          end else begin
            diff_q  <= tick_q - cur.last_tick;
            state_q <= ST_SNAP_FRESH;
          end
        end

        ST_SNAP_FRESH: begin
          if (diff_q[TICK_W-1:TICK_W-2] != 2'b00 ||
              {diff_q, 1'b0} > (TICK_W+1)'(tr5_q)) begin
            idx_q   <= idx_nxt;
            state_q <= snap_nxt;
          end else begin
            h_q     <= cur.head;
            n_q     <= cur.fill;
            pos_q   <= ring_pos(cur.head, cur.fill - CNT_W'(1));
            state_q <= ST_SNAP_LAST_RD;
          end
        end

        ST_SNAP_LAST_RD:  state_q <= ST_SNAP_LAST_GET;

        ST_SNAP_LAST_GET: begin
          last_q  <= ring_rd_q;
          state_q <= ST_SNAP_WIN_RD;
        end

        ST_SNAP_WIN_RD: state_q <= ST_SNAP_WIN_CMP;

        ST_SNAP_WIN_CMP: begin
          // trim a private copy against the current window
          if (n_q > CNT_W'(1) && trim_hit) begin
            h_q     <= ring_pos(h_q, CNT_W'(1));
            n_q     <= n_q - CNT_W'(1);
            state_q <= ST_SNAP_WIN_RD;
          end else if (div_start) begin
            state_q <= ST_SNAP_DIV;
          end else begin
            idx_q   <= idx_nxt;
            state_q <= snap_nxt;
          end
        end

        ST_SNAP_DIV: begin
          if (div_done) begin
            if (div_quo >= NUM_W'(RATE_LO_Q8) && div_quo <= NUM_W'(RATE_HI_Q8) && better) begin
              avail_q    <= 1'b1;
              best_q_q   <= div_quo[Q_W-1:0];
              best_fg_q  <= fg;
              best_pid_q <= cur.process;
            end
            idx_q   <= idx_nxt;
            state_q <= snap_nxt;
          end
        end

        ST_FINISH: begin
          if (!out_valid_q || rsp.ready) begin
            out_valid_q <= 1'b1;
            out_acc_q   <= acc_q;
            out_avail_q <= avail_q;
            out_rate_q  <= avail_q ? rnd[Q_W-1:8] : '0;
            out_pid_q   <= avail_q ? best_pid_q : '0;
            state_q     <= ST_IDLE;
          end
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign req.ready          = state_q == ST_IDLE;
  assign rsp.valid          = out_valid_q;
  assign rsp.available      = out_avail_q;
  assign rsp.rate_fps       = out_rate_q;
  assign rsp.chosen_process = out_pid_q;
  assign rsp.accepted       = out_acc_q;

`ifndef SYNTHESIS
  a_div_idle_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.valid && req.ready |-> !div_busy)
    else $error("divider busy while a transaction is accepted");

  a_result_consistent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && rsp.available |-> rsp.rate_fps != '0 && !rsp.accepted)
    else $error("snapshot result with zero rate or record flag");

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur.fill <= CNT_W'(RING_DEPTH))
    else $error("slot fill exceeds ring depth");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.accepted) &&
      $stable(rsp.available) && $stable(rsp.rate_fps) && $stable(rsp.chosen_process))
    else $error("response changed while waiting");
`endif

endmodule

/* rtl/psfrm_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
// Standalone; used by the top level for the Q14.8 rate quotient.
module psfrm_div #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DEN_W-1:0] rem_q, den_q;
  logic [NUM_W-1:0] quo_q;

  logic [DEN_W:0]   rem_sh, rem_sub;
  logic             ge;

  always_comb begin
    rem_sh  = {rem_q, quo_q[NUM_W-1]};
    rem_sub = rem_sh - {1'b0, den_q};
    ge      = rem_sh >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      rem_q <= '0;
      den_q <= den_i;
      quo_q <= num_i;
    end else if (busy_q) begin
      rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      quo_q <= {quo_q[NUM_W-2:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

/* tb/per_stream_frame_rate_meter_tb.sv */
// Self-checking testbench for per_stream_frame_rate_meter.
// Depends on psfrm_pkg and the psfrm_req_if / psfrm_rsp_if interfaces.
// Predicts each response from a model of the slot table and compares in order.
module per_stream_frame_rate_meter_tb;
  import psfrm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = SLOTS_DEF;
  localparam int DEPTH = RING_DEPTH_DEF;
  localparam int NSTREAM = 10;
  localparam int LIMIT = 20000000;

  typedef struct packed {
    logic              available;
    logic [RATE_W-1:0] rate_fps;
    logic [PID_W-1:0]  chosen_process;
    logic              accepted;
  } meter_result_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [0:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  psfrm_req_if req_if ();
  psfrm_rsp_if rsp_if ();

  per_stream_frame_rate_meter DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req_if),
    .rsp        (rsp_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Predictor state
  int unsigned      win_ms;
  longint unsigned  tick_hz;
  bit               sl_valid [NSLOT];
  bit [PID_W-1:0]   sl_pid   [NSLOT];
  bit [CHAIN_W-1:0] sl_chain [NSLOT];
  bit               sl_game  [NSLOT];
  longint           sl_tick  [NSLOT];
  int               sl_head  [NSLOT];
  int               sl_fill  [NSLOT];
  bit [TIME_W-1:0]  present_ring [NSLOT][DEPTH];

  meter_result_t expected_results[$];
  int mismatches;
  int results_seen;
  int cycles;
  int stall_left;
  bit no_idle;

  // Stream pool for random records
  bit [PID_W-1:0]   st_pid   [NSTREAM];
  bit [CHAIN_W-1:0] st_chain [NSTREAM];
  bit [TIME_W-1:0]  st_time  [NSTREAM];
  int unsigned      st_period[NSTREAM];
  bit               st_game  [NSTREAM];
  longint           wall_tick;

  initial begin
    clk_i = 1'b0;
  end
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Response-side backpressure
  always @(posedge clk_i) begin
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || stall_left == 0) begin
      rsp_if.ready <= 1'b1;
      if (!no_idle && r < 15) stall_left <= $urandom_range(1, 3);
      else if (!no_idle && r < 18) stall_left <= $urandom_range(20, 60);
      else stall_left <= 0;
    end else begin
      rsp_if.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end
  end

  // Sample handshakes at the falling edge; transaction completes at the next rising edge.
  always @(negedge clk_i) begin
    meter_result_t got, want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      got = {rsp_if.available, rsp_if.rate_fps, rsp_if.chosen_process, rsp_if.accepted};
      results_seen++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", got);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected avail=%0b fps=%0d pid=%0h acc=%0b",
                     want.available, want.rate_fps, want.chosen_process, want.accepted);
            $display("          got      avail=%0b fps=%0d pid=%0h acc=%0b",
                     got.available, got.rate_fps, got.chosen_process, got.accepted);
          end
        end
      end
    end
  end

  function automatic bit [TIME_W-1:0] ring_time(int s, int pos);
    return present_ring[s][pos % DEPTH];
  endfunction

  function automatic void clear_stream(int s);
    sl_valid[s] = 0; sl_pid[s] = '0; sl_chain[s] = '0; sl_game[s] = 0;
    sl_tick[s] = 0; sl_head[s] = 0; sl_fill[s] = 0;
  endfunction

  function automatic longint unsigned window_rate_q8(int s);
    int head, n;
    longint unsigned newest, win, span;
    head = sl_head[s];
    n = sl_fill[s];
    if (!sl_valid[s] || n < 2) return 0;
    newest = ring_time(s, head + n - 1);
    win = longint'(win_ms) * MS_TO_US;
    while (n > 1 && longint'(ring_time(s, head)) + win < newest) begin
      head = (head + 1) % DEPTH;
      n--;
    end
    if (n < 2) return 0;
    span = newest - ring_time(s, head);
    if (span <= MIN_SPAN_US) return 0;
    return (64'd256000000 * longint'(n - 1)) / span;
  endfunction

  function automatic bit record_present(bit [PID_W-1:0] pid, bit [CHAIN_W-1:0] ch,
                                        bit [TIME_W-1:0] t, longint tk, bit game);
    int sel, oldest, pos;
    longint unsigned win;
    sel = NSLOT;
    oldest = 0;
    if (pid == 0) return 0;
    for (int s = 0; s < NSLOT; s++) begin
      if (sl_valid[s] && sl_pid[s] == pid && sl_chain[s] == ch) begin
        sel = s;
        break;
      end
      if (!sl_valid[s] && sel == NSLOT) sel = s;
      if (sl_tick[s] < sl_tick[oldest]) oldest = s;
    end
    if (sel == NSLOT) sel = oldest;
    if (!sl_valid[sel] || sl_pid[sel] != pid || sl_chain[sel] != ch) begin
      clear_stream(sel);
      sl_valid[sel] = 1; sl_pid[sel] = pid; sl_chain[sel] = ch; sl_game[sel] = game;
    end
    if (sl_fill[sel] != 0 && t <= ring_time(sel, sl_head[sel] + sl_fill[sel] - 1)) return 0;
    if (sl_fill[sel] >= DEPTH) begin
      sl_head[sel] = (sl_head[sel] + 1) % DEPTH;
      sl_fill[sel] = DEPTH - 1;
    end
    pos = (sl_head[sel] + sl_fill[sel]) % DEPTH;
    present_ring[sel][pos] = t;
    sl_fill[sel]++;
    sl_tick[sel] = tk;
    win = longint'(win_ms) * MS_TO_US;
    while (sl_fill[sel] > 1 && longint'(ring_time(sel, sl_head[sel])) + win < t) begin
      sl_head[sel] = (sl_head[sel] + 1) % DEPTH;
      sl_fill[sel]--;
    end
    return 1;
  endfunction

  function automatic meter_result_t pick_best_stream(bit [PID_W-1:0] fg_pid, longint now,
                                                     bit games);
    meter_result_t res;
    bit best_fg, fg;
    longint unsigned best_q, q, diff, r;
    res = '0;
    best_fg = 0;
    best_q = 0;
    for (int s = 0; s < NSLOT; s++) begin
      if (!sl_valid[s] || sl_fill[s] < 2) continue;
      if (tick_hz == 0 || now < sl_tick[s]) continue;
      diff = longint'(now) - longint'(sl_tick[s]);
      if (diff >= 64'h4000_0000_0000_0000 || 2 * diff > 5 * tick_hz) continue;
      if (games && !sl_game[s]) continue;
      q = window_rate_q8(s);
      if (q < RATE_LO_Q8 || q > RATE_HI_Q8) continue;
      fg = (sl_pid[s] == fg_pid);
      if (!res.available || (fg && !best_fg) || (fg == best_fg && q > best_q)) begin
        res.available = 1;
        best_q = q;
        best_fg = fg;
        res.chosen_process = sl_pid[s];
      end
    end
    if (res.available) begin
      r = (best_q + ROUND_Q8) >> 8;
      if (r < 1) r = 1;
      if (r > 9999) r = 9999;
      res.rate_fps = r[RATE_W-1:0];
    end
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  // Called at a rising edge; returns at the rising edge that completes the transaction.
  task automatic send_item(func_e f, bit [PID_W-1:0] pid, bit [CHAIN_W-1:0] ch,
                           bit [TIME_W-1:0] t, longint tk, bit kg, bit go);
    int gap;
    meter_result_t exp_res;
    gap = pick_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.func <= f;
    req_if.src_pid <= pid;
    req_if.chain_id <= ch;
    req_if.event_time_us <= t;
    req_if.tick_time <= tk;
    req_if.is_game <= kg;
    req_if.only_games <= go;
    do @(negedge clk_i); while (!req_if.ready);
    exp_res = '0;
    case (f)
      FUNC_RECORD:   exp_res.accepted = record_present(pid, ch, t, tk, kg);
      FUNC_SNAPSHOT: exp_res = pick_best_stream(pid, tk, go);
      FUNC_CLEAR:    for (int s = 0; s < NSLOT; s++) clear_stream(s);
      default: ;
    endcase
    expected_results.push_back(exp_res);
    @(posedge clk_i);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, bit [CFG_DATA_W-1:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_SMOOTHING)
      win_ms = (val < SMOOTH_LO) ? SMOOTH_LO : (val > SMOOTH_HI) ? SMOOTH_HI : int'(val);
    else
      tick_hz = val;
  endtask

  task automatic record_stream(int k);
    int unsigned step;
    bit [TIME_W-1:0] t;
    wall_tick += $urandom_range(1, 200000);
    step = st_period[k] + $urandom_range(0, st_period[k] / 4) - st_period[k] / 8;
    if ($urandom_range(0, 19) == 0) t = st_time[k] - $urandom_range(0, 2);  // stale time
    else begin
      t = st_time[k] + step;
      st_time[k] = t;
    end
    send_item(FUNC_RECORD, st_pid[k], st_chain[k], t, wall_tick, st_game[k], $urandom);
  endtask

  task automatic snapshot_now();
    int r;
    longint tk;
    r = $urandom_range(0, 9);
    tk = wall_tick + $urandom_range(0, 100000);
    if (r == 0) tk = wall_tick + 64'(20000000 + $urandom_range(0, 10000000));
    else if (r == 1) tk = wall_tick - $urandom_range(1, 1000000);
    send_item(FUNC_SNAPSHOT,
              ($urandom_range(0, 2) == 0) ? $urandom : st_pid[$urandom_range(0, NSTREAM-1)],
              {$urandom, $urandom}, {$urandom, $urandom}, tk, $urandom,
              $urandom_range(0, 3) == 0);
  endtask

  task automatic test_directed();
    send_item(FUNC_SNAPSHOT, 0, 0, 0, 0, 0, 0);
    send_item(FUNC_RECORD, 0, '1, 1000, 5, 1, 0);                  // zero process rejected
    send_item(FUNC_NONE, '1, '1, '1, -1, 1, 1);
    send_item(FUNC_RECORD, '1, '1, 1000, 100, 1, 0);
    send_item(FUNC_RECORD, '1, '1, 1000, 120, 1, 0);                // not newer
    send_item(FUNC_RECORD, '1, '1, 1040, 150, 1, 0);
    send_item(FUNC_SNAPSHOT, '1, 0, 0, 160, 0, 0);                  // span too short
    send_item(FUNC_RECORD, '1, '1, 17000, 200, 1, 0);
    send_item(FUNC_SNAPSHOT, '1, 0, 0, 300, 0, 0);
    send_item(FUNC_SNAPSHOT, 5, 0, 0, 50, 0, 1);                    // now below last tick
    send_item(FUNC_RECORD, 7, 0, 0, 64'sh8000_0000_0000_0000, 0, 0);
    send_item(FUNC_RECORD, 7, 0, 101, 64'sh8000_0000_0000_0000, 0, 1);
    send_item(FUNC_SNAPSHOT, 7, 0, 0, 64'sh7FFF_FFFF_FFFF_FFFF, 0, 0); // huge gap, stale
    send_item(FUNC_SNAPSHOT, 7, 0, 0, 400, 0, 1);                   // games only
    send_item(FUNC_RECORD, 7, 0, 48'hFFFF_FFFF_FFFF, 500, 0, 0);    // window trims all but one
    send_item(FUNC_RECORD, 9, 1, 0, 600, 0, 0);
    send_item(FUNC_RECORD, 9, 1, 1000000, 700, 0, 0);                // one frame per second
    send_item(FUNC_SNAPSHOT, 0, 0, 0, 800, 0, 0);
    write_reg(CFG_TICK_RATE, 0);
    send_item(FUNC_SNAPSHOT, 9, 0, 0, 800, 0, 0);                   // zero rate: all stale
    write_reg(CFG_TICK_RATE, CFG_DATA_W'(TICK_RATE_RST));
    send_item(FUNC_CLEAR, '1, '1, '1, -1, 1, 1);
    send_item(FUNC_SNAPSHOT, '1, 0, 0, 800, 0, 0);
  endtask

  // Fill one ring past its depth at 1 kHz; shrink the window, then query again.
  task automatic test_ring_wrap();
    bit [TIME_W-1:0] t;
    write_reg(CFG_SMOOTHING, SMOOTH_HI);
    t = 48'd5000000;
    for (int i = 0; i < 300; i++) begin
      t += 1000;
      send_item(FUNC_RECORD, 32'h55, 64'h1234, t, 1000 + i, 1, 0);
    end
    send_item(FUNC_SNAPSHOT, 0, 0, 0, 1400, 0, 0);
    write_reg(CFG_SMOOTHING, 0);  // clamps to the minimum, snapshot trims again
    send_item(FUNC_SNAPSHOT, 0, 0, 0, 1400, 0, 1);
    write_reg(CFG_SMOOTHING, '1);
    send_item(FUNC_SNAPSHOT, 32'h55, 0, 0, 1400, 0, 0);
    send_item(FUNC_CLEAR, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic run_traffic(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r == 0) drain();  // let every expected response arrive before continuing
      if (r < 72) record_stream($urandom_range(0, NSTREAM-1));
      else if (r < 90) snapshot_now();
      else if (r < 92) send_item(FUNC_CLEAR, $urandom, {$urandom, $urandom},
                                 {$urandom, $urandom}, {$urandom, $urandom}, $urandom, $urandom);
      else if (r < 94) send_item(FUNC_NONE, $urandom, {$urandom, $urandom},
                                 {$urandom, $urandom}, {$urandom, $urandom}, $urandom, $urandom);
      else send_item(FUNC_RECORD, (r < 96) ? 0 : $urandom, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom}, $urandom, $urandom);
    end
  endtask

  task automatic test_random();
    int unsigned periods [NSTREAM] = '{100, 101, 1000, 4167, 8333, 16000, 16667, 33333,
                                       100000, 1000000};
    for (int k = 0; k < NSTREAM; k++) begin
      st_pid[k] = (k < 8) ? k + 1 : $urandom;
      st_chain[k] = (k == 1) ? 64'd0 : {$urandom, $urandom};
      st_time[k] = 48'd1000000 + $urandom_range(0, 100000);
      st_period[k] = periods[k];
      st_game[k] = $urandom;
    end
    st_pid[9] = st_pid[0];  // same process, second chain
    wall_tick = 64'd1000000;
    write_reg(CFG_SMOOTHING, SMOOTH_RST);
    write_reg(CFG_TICK_RATE, CFG_DATA_W'(TICK_RATE_RST));
    run_traffic(250);
    write_reg(CFG_SMOOTHING, SMOOTH_LO);
    write_reg(CFG_TICK_RATE, 40'hFF_FFFF_FFFF);
    run_traffic(200);
    write_reg(CFG_SMOOTHING, 11'd2000);
    write_reg(CFG_TICK_RATE, 1);
    no_idle = 1;
    run_traffic(100);
    no_idle = 0;
    write_reg(CFG_SMOOTHING, 700);
    write_reg(CFG_TICK_RATE, 40'd1000000);
    run_traffic(200);
    write_reg(CFG_TICK_RATE, CFG_DATA_W'(TICK_RATE_RST));
    run_traffic(150);
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_SMOOTHING;
    cfg_data_i = '0;
    req_if.valid = 1'b0;
    req_if.func = FUNC_NONE;
    req_if.src_pid = '0;
    req_if.chain_id = '0;
    req_if.event_time_us = '0;
    req_if.tick_time = '0;
    req_if.is_game = 1'b0;
    req_if.only_games = 1'b0;
    rsp_if.ready = 1'b0;
    stall_left = 0;
    no_idle = 0;
    mismatches = 0;
    results_seen = 0;
    cycles = 0;
    win_ms = SMOOTH_RST;
    tick_hz = TICK_RATE_RST;
    for (int s = 0; s < NSLOT; s++) clear_stream(s);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_ring_wrap();
    test_random();

    drain();
    repeat (50) @(posedge clk_i);
    $display("Covered records, snapshots, clears, idle codes, ring wrap and eviction;");
    $display("%0d responses checked over five register settings, %0d mismatches.",
             results_seen, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
